>>> design/rpa_pkg.sv
// Shared types and constants of the reference-counted page allocator.
package rpa_pkg;

	localparam int ADDR_W      = 56;
	localparam int PAGE_SHIFT  = 12;
	localparam int PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;
	localparam int KIND_W      = 3;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 8;
	localparam int FREE_W      = 16;
	localparam int CFG_ADDR_W  = 4;
	localparam int CFG_DATA_W  = 64;
	localparam int REG_SEL_BIT = 3;

	localparam logic [ADDR_W-1:0] CFG_RESET = 56'h0000_0080_0000_00;

	typedef enum logic [KIND_W-1:0] {
		KIND_INIT       = 3'd0,
		KIND_ALLOC      = 3'd1,
		KIND_FREE       = 3'd2,
		KIND_ADD_REF    = 3'd3,
		KIND_DROP_REF   = 3'd4,
		KIND_READ_COUNT = 3'd5
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_EMPTY    = 2'd1,
		STATUS_BAD_ADDR = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_MEMORY_BASE  = 1'b0,
		REG_USABLE_START = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_INIT_PREP,
		ST_INIT_WALK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic rd_idx;
		logic init_prep;
		logic init_push;
		logic clear_step;
		logic finish;
	} rpa_cmd_t;

	typedef struct packed {
		logic walk_last;
		logic init_none;
		logic out_free;
	} rpa_stat_t;

endpackage

>>> design/rpa_req_if.sv
// Command channel carrying one allocator command per transfer.
interface rpa_req_if import rpa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [ADDR_W-1:0]   page_address;

	modport source (output valid, output kind, output page_address, input ready);
	modport sink (input valid, input kind, input page_address, output ready);
endinterface

>>> design/rpa_rsp_if.sv
// Result channel carrying one allocator result per transfer.
interface rpa_rsp_if import rpa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic [ADDR_W-1:0]      allocated_address;
	logic [COUNT_OUT_W-1:0] reference_count;
	logic                   page_released;
	logic [FREE_W-1:0]      free_pages;

	modport source (output valid, output status, output allocated_address,
		output reference_count, output page_released, output free_pages, input ready);
	modport sink (input valid, input status, input allocated_address,
		input reference_count, input page_released, input free_pages, output ready);
endinterface

>>> design/rpa_cfg.sv
// APB register file holding the memory base and usable start addresses.
module rpa_cfg import rpa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [ADDR_W-1:0]     memory_base,
	output logic [ADDR_W-1:0]     usable_start
);

	logic [ADDR_W-1:0] memory_base_q;
	logic [ADDR_W-1:0] usable_start_q;
	reg_idx_t          sel;
	logic              wr_en;

	assign pready = 1'b1;
	assign sel    = reg_idx_t'(paddr[REG_SEL_BIT]);
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memory_base_q  <= CFG_RESET;
			usable_start_q <= CFG_RESET;
		end else if (wr_en) begin
			case (sel)
				REG_MEMORY_BASE: begin
					memory_base_q <= pwdata[ADDR_W-1:0];
				end
				REG_USABLE_START: begin
					usable_start_q <= pwdata[ADDR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_MEMORY_BASE: begin
				prdata = {{(CFG_DATA_W-ADDR_W){1'b0}}, memory_base_q};
			end
			REG_USABLE_START: begin
				prdata = {{(CFG_DATA_W-ADDR_W){1'b0}}, usable_start_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign memory_base  = memory_base_q;
	assign usable_start = usable_start_q;

endmodule

>>> design/rpa_ctrl.sv
// Controller state machine sequencing clearing, init walks and commands.
module rpa_ctrl import rpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] in_kind,
	output logic              in_ready,
	input  rpa_stat_t         stat,
	output rpa_cmd_t          cmd
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.walk_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (in_kind)
						KIND_INIT: begin
							state_nx = ST_INIT_PREP;
						end
						KIND_FREE, KIND_ADD_REF, KIND_DROP_REF, KIND_READ_COUNT: begin
							state_nx = ST_CHECK;
						end
						default: begin
							state_nx = ST_FINISH;
						end
					endcase
				end
			end
			ST_CHECK: begin
				cmd.rd_idx = 1'b1;
				state_nx   = ST_FINISH;
			end
			ST_INIT_PREP: begin
				cmd.init_prep = 1'b1;
				state_nx      = stat.init_none ? ST_FINISH : ST_INIT_WALK;
			end
			ST_INIT_WALK: begin
				cmd.init_push = 1'b1;
				if (stat.walk_last) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/rpa_datapath.sv
// Datapath with the count and link memories, list head, counter and result register.
module rpa_datapath import rpa_pkg::*; #(
	parameter int NUM_PAGES   = 32768,
	parameter int COUNT_WIDTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rpa_cmd_t               cmd,
	output rpa_stat_t              stat,
	input  logic [ADDR_W-1:0]      memory_base,
	input  logic [ADDR_W-1:0]      usable_start,
	input  logic [KIND_W-1:0]      in_kind,
	input  logic [ADDR_W-1:0]      in_addr,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [STATUS_W-1:0]    out_status,
	output logic [ADDR_W-1:0]      out_alloc_addr,
	output logic [COUNT_OUT_W-1:0] out_count,
	output logic                   out_released,
	output logic [FREE_W-1:0]      out_free
);

	localparam int IDX_W  = $clog2(NUM_PAGES);
	localparam int LINK_W = IDX_W + 1;
	localparam int INIT_W = PAGE_NUM_W + 2;
	localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(NUM_PAGES - 1);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [FREE_W-1:0]      FREE_MAX  = '1;

	logic [COUNT_WIDTH-1:0] count_mem [NUM_PAGES];
	logic [LINK_W-1:0]      link_mem [NUM_PAGES];

	logic [COUNT_WIDTH-1:0] cnt_rd_q;
	logic [LINK_W-1:0]      link_rd_q;
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic                   cnt_we;
	logic [IDX_W-1:0]       wr_addr;
	logic [COUNT_WIDTH-1:0] cnt_wd;
	logic                   link_we;

	logic [IDX_W-1:0]  head_q;
	logic              head_valid_q;
	logic [FREE_W-1:0] counter_q;
	logic [IDX_W-1:0]  walk_q;
	logic              out_valid_q;

	logic [KIND_W-1:0]     kind_q;
	logic                  bad_pre_q;
	logic [PAGE_NUM_W-1:0] diff_pg_q;
	logic [INIT_W-1:0]     init_diff_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  ok_q;

	logic [PAGE_NUM_W-1:0] base_pg;
	logic [PAGE_NUM_W:0]   diff_ext;
	logic [INIT_W-1:0]     init_diff;
	logic                  pre_bad;
	logic [IDX_W-1:0]      first_idx;

	logic [STATUS_W-1:0]            res_status;
	logic [ADDR_W-1:0]              res_addr;
	logic [COUNT_WIDTH-1:0]         res_count;
	logic [COUNT_WIDTH+COUNT_OUT_W-1:0] res_count_wide;
	logic                           res_rel;
	logic [COUNT_WIDTH-1:0]         cnt_new;
	logic                           fin_cnt_wr;
	logic                           do_pop;
	logic                           do_push;
	logic [FREE_W-1:0]              counter_nx;
	logic [FREE_W-1:0]              counter_inc;

	assign base_pg  = memory_base[ADDR_W-1:PAGE_SHIFT];
	assign diff_ext = {1'b0, in_addr[ADDR_W-1:PAGE_SHIFT]} - {1'b0, base_pg};
	assign pre_bad  = (|in_addr[PAGE_SHIFT-1:0]) | (in_addr < usable_start)
		| diff_ext[PAGE_NUM_W];
	assign init_diff = {2'b00, usable_start[ADDR_W-1:PAGE_SHIFT]} - {2'b00, base_pg}
		+ INIT_W'(|usable_start[PAGE_SHIFT-1:0]);
	assign first_idx = init_diff_q[INIT_W-1] ? '0 : init_diff_q[IDX_W-1:0];

	assign stat.walk_last = (walk_q == LAST_IDX);
	assign stat.init_none = !init_diff_q[INIT_W-1] && (init_diff_q >= INIT_W'(NUM_PAGES));
	assign stat.out_free  = !out_valid_q || out_ready;

	assign rd_en   = cmd.accept | cmd.rd_idx;
	assign rd_addr = cmd.rd_idx ? diff_pg_q[IDX_W-1:0] : head_q;

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			count_mem[wr_addr] <= cnt_wd;
		end
		if (rd_en) begin
			cnt_rd_q <= count_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[wr_addr] <= {head_valid_q, head_q};
		end
		if (rd_en) begin
			link_rd_q <= link_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q      <= in_kind;
			bad_pre_q   <= pre_bad;
			diff_pg_q   <= diff_ext[PAGE_NUM_W-1:0];
			init_diff_q <= init_diff;
			idx_q       <= head_q;
		end
		if (cmd.rd_idx) begin
			ok_q  <= !bad_pre_q && (diff_pg_q < PAGE_NUM_W'(NUM_PAGES));
			idx_q <= diff_pg_q[IDX_W-1:0];
		end
	end

	always_comb begin
		res_status = STATUS_OK;
		res_addr   = '0;
		res_count  = '0;
		res_rel    = 1'b0;
		cnt_new    = cnt_rd_q;
		fin_cnt_wr = 1'b0;
		do_pop     = 1'b0;
		do_push    = 1'b0;
		case (kind_q)
			KIND_ALLOC: begin
				if (!head_valid_q) begin
					res_status = STATUS_EMPTY;
				end else begin
					do_pop     = 1'b1;
					fin_cnt_wr = 1'b1;
					cnt_new    = (cnt_rd_q != COUNT_MAX) ? cnt_rd_q + 1'b1 : cnt_rd_q;
					res_count  = cnt_new;
					res_addr   = {base_pg + PAGE_NUM_W'(idx_q), {PAGE_SHIFT{1'b0}}};
				end
			end
			KIND_FREE, KIND_ADD_REF, KIND_DROP_REF, KIND_READ_COUNT: begin
				if (!ok_q) begin
					res_status = STATUS_BAD_ADDR;
				end else begin
					if (kind_q == KIND_ADD_REF) begin
						cnt_new = (cnt_rd_q != COUNT_MAX) ? cnt_rd_q + 1'b1 : cnt_rd_q;
					end else if (kind_q == KIND_FREE || kind_q == KIND_DROP_REF) begin
						cnt_new = (cnt_rd_q != '0) ? cnt_rd_q - 1'b1 : cnt_rd_q;
					end
					fin_cnt_wr = 1'b1;
					do_push    = (kind_q == KIND_FREE) && (cnt_new == '0);
					res_rel    = do_push;
					res_count  = cnt_new;
				end
			end
			default: begin
			end
		endcase
	end

	assign counter_inc = (counter_q != FREE_MAX) ? counter_q + 1'b1 : counter_q;

	always_comb begin
		counter_nx = counter_q;
		if (do_pop && counter_q != '0) begin
			counter_nx = counter_q - 1'b1;
		end else if (do_push) begin
			counter_nx = counter_inc;
		end
	end

	assign res_count_wide = {{COUNT_OUT_W{1'b0}}, res_count};

	assign cnt_we  = cmd.clear_step | cmd.init_push | (cmd.finish & fin_cnt_wr);
	assign link_we = cmd.init_push | (cmd.finish & do_push);
	assign wr_addr = cmd.finish ? idx_q : walk_q;
	assign cnt_wd  = cmd.finish ? cnt_new : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			head_valid_q <= 1'b0;
			counter_q    <= '0;
			walk_q       <= '0;
		end else begin
			if (cmd.clear_step) begin
				walk_q <= walk_q + 1'b1;
			end
			if (cmd.init_prep) begin
				head_q       <= '0;
				head_valid_q <= 1'b0;
				counter_q    <= '0;
				walk_q       <= first_idx;
			end
			if (cmd.init_push) begin
				head_q       <= walk_q;
				head_valid_q <= 1'b1;
				counter_q    <= counter_inc;
				walk_q       <= walk_q + 1'b1;
			end
			if (cmd.finish) begin
				counter_q <= counter_nx;
				if (do_pop) begin
					head_q       <= link_rd_q[IDX_W-1:0];
					head_valid_q <= link_rd_q[IDX_W];
				end else if (do_push) begin
					head_q       <= idx_q;
					head_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_status     <= res_status;
			out_alloc_addr <= res_addr;
			out_count      <= res_count_wide[COUNT_OUT_W-1:0];
			out_released   <= res_rel;
			out_free       <= counter_nx;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/refcounted_page_allocator_top.sv
// Top level of the reference-counted page allocator.
// Commands arrive on req (valid/ready) and each gives exactly one result on rsp.
// Configuration goes through the APB port: memory_base at byte address 0 and
// usable_start at byte address 8, 64-bit data, no wait states.
// After the accepting edge, allocate and unknown kinds go straight to the finish
// state; free, add reference, drop reference and read count first pass a check
// state for the page range check and count read; init passes a prep state and,
// unless no page is to be pushed, a walk state that pushes one page per cycle
// through the single write port of the count and link memories.
// One command is in flight at a time, so a new command is taken only once the
// previous one has finished; req.ready is high whenever the controller
// is idle, even while the previous result still waits in the output register.
// When rsp stalls, a finished command holds in the controller until the output
// register frees up, and no further transfer is taken.
// After reset every page of the count memory is cleared, one page per cycle,
// with req.ready low; APB writes are taken during that time.
module refcounted_page_allocator_top import rpa_pkg::*; #(
	parameter int NUM_PAGES   = 32768,
	parameter int COUNT_WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rpa_req_if.sink               req,
	rpa_rsp_if.source             rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [ADDR_W-1:0] memory_base;
	logic [ADDR_W-1:0] usable_start;
	rpa_cmd_t          cmd;
	rpa_stat_t         stat;

	rpa_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.memory_base  (memory_base),
		.usable_start (usable_start)
	);

	rpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_kind  (req.kind),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rpa_datapath #(
		.NUM_PAGES   (NUM_PAGES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.memory_base    (memory_base),
		.usable_start   (usable_start),
		.in_kind        (req.kind),
		.in_addr        (req.page_address),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.out_status     (rsp.status),
		.out_alloc_addr (rsp.allocated_address),
		.out_count      (rsp.reference_count),
		.out_released   (rsp.page_released),
		.out_free       (rsp.free_pages)
	);

endmodule

>>> dv/tb_refcounted_page_allocator_top.sv
// Self-checking testbench for the page allocator, checked against a behavioral free list.
module tb_refcounted_page_allocator_top import rpa_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PAGES = 32768;
	localparam int COUNT_W = 8;
	localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
	localparam longint unsigned PAGE_BYTES = 64'd4096;
	localparam logic [63:0] PAGE_MASK = PAGE_BYTES - 1;
	localparam longint unsigned WINDOW = 48;
	localparam int SMALL_INIT = 64;
	localparam int SEND_GAP_PCT = 67;
	localparam int RECV_GAP_PCT = 67;
	localparam int BOTH_GAP_PCT = 24;
	localparam int HOLD_CYCLES = 600;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int REPORT_MAX = 10;
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

	typedef enum {GAPS_NONE, GAPS_SEND, GAPS_RECV, GAPS_BOTH} gap_mode_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] page_address;
	} alloc_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [ADDR_W-1:0]      allocated_address;
		logic [COUNT_OUT_W-1:0] reference_count;
		logic                   page_released;
		logic [FREE_W-1:0]      free_pages;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	rpa_req_if cmd_ch ();
	rpa_rsp_if res_ch ();

	refcounted_page_allocator_top #(
		.NUM_PAGES(NUM_PAGES),
		.COUNT_WIDTH(COUNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(cmd_ch),
		.rsp(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	// Shadow of the allocator state.
	int unsigned page_refs [NUM_PAGES];
	int unsigned page_link [NUM_PAGES];
	bit link_ok [NUM_PAGES];
	int unsigned head;
	bit head_ok;
	logic [FREE_W-1:0] free_cnt = '0;
	logic [ADDR_W-1:0] cfg_base = CFG_RESET;
	logic [ADDR_W-1:0] cfg_usable = CFG_RESET;

	alloc_cmd_t cmds_to_send [$];
	alloc_result_t results_due [$];
	alloc_cmd_t in_flight;
	int cmds_queued = 0;
	int cmds_accepted = 0;
	int results_seen = 0;
	int mismatch_count = 0;
	int hold_at = -1;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int cycle_count = 0;
	gap_mode_t gap_mode = GAPS_NONE;

	function automatic logic [63:0] base_aligned();
		return {8'b0, cfg_base} & ~PAGE_MASK;
	endfunction

	function automatic longint unsigned init_first_page();
		logic [63:0] start;
		start = ({8'b0, cfg_usable} + PAGE_MASK) & ~PAGE_MASK;
		if (start < base_aligned())
			start = base_aligned();
		return (start - base_aligned()) >> PAGE_SHIFT;
	endfunction

	function automatic logic [ADDR_W-1:0] page_at(input longint unsigned idx);
		return ADDR_W'(base_aligned() + (idx << PAGE_SHIFT));
	endfunction

	function automatic void push_page(input int unsigned idx);
		page_link[idx] = head;
		link_ok[idx] = head_ok;
		head = idx;
		head_ok = 1'b1;
		if (free_cnt != '1)
			free_cnt++;
	endfunction

	function automatic bit lookup_page(input logic [ADDR_W-1:0] a, output int unsigned idx);
		logic [63:0] addr;
		logic [63:0] off;
		addr = {8'b0, a};
		idx = 0;
		if ((addr & PAGE_MASK) != 0)
			return 1'b0;
		if (addr < {8'b0, cfg_usable} || addr < base_aligned())
			return 1'b0;
		off = (addr - base_aligned()) >> PAGE_SHIFT;
		if (off >= NUM_PAGES)
			return 1'b0;
		idx = int'(off);
		return 1'b1;
	endfunction

	function automatic alloc_result_t apply_command(input alloc_cmd_t c);
		alloc_result_t r;
		int unsigned idx;
		longint unsigned i;
		r = '0;
		r.status = STATUS_OK;
		case (c.kind)
			KIND_INIT: begin
				head_ok = 1'b0;
				head = 0;
				free_cnt = '0;
				for (i = init_first_page(); i < NUM_PAGES; i++) begin
					page_refs[i] = 0;
					push_page(int'(i));
				end
			end
			KIND_ALLOC: begin
				if (!head_ok) begin
					r.status = STATUS_EMPTY;
				end else begin
					idx = head;
					head = page_link[idx];
					head_ok = link_ok[idx];
					if (page_refs[idx] < COUNT_MAX)
						page_refs[idx]++;
					if (free_cnt != 0)
						free_cnt--;
					r.allocated_address = page_at(idx);
					r.reference_count = COUNT_OUT_W'(page_refs[idx]);
				end
			end
			KIND_FREE, KIND_ADD_REF, KIND_DROP_REF, KIND_READ_COUNT: begin
				if (!lookup_page(c.page_address, idx)) begin
					r.status = STATUS_BAD_ADDR;
				end else begin
					case (c.kind)
						KIND_FREE: begin
							if (page_refs[idx] > 0)
								page_refs[idx]--;
							if (page_refs[idx] == 0) begin
								push_page(idx);
								r.page_released = 1'b1;
							end
						end
						KIND_ADD_REF: begin
							if (page_refs[idx] < COUNT_MAX)
								page_refs[idx]++;
						end
						KIND_DROP_REF: begin
							if (page_refs[idx] > 0)
								page_refs[idx]--;
						end
						default: ;
					endcase
					r.reference_count = COUNT_OUT_W'(page_refs[idx]);
				end
			end
			default: ;
		endcase
		r.free_pages = free_cnt;
		return r;
	endfunction

	function automatic bit send_pause();
		if (gap_mode == GAPS_SEND)
			return $urandom_range(0, 99) < SEND_GAP_PCT;
		if (gap_mode == GAPS_BOTH)
			return $urandom_range(0, 99) < BOTH_GAP_PCT;
		return 1'b0;
	endfunction

	function automatic bit recv_pause();
		if (gap_mode == GAPS_RECV)
			return $urandom_range(0, 99) < RECV_GAP_PCT;
		if (gap_mode == GAPS_BOTH)
			return $urandom_range(0, 99) < BOTH_GAP_PCT;
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		alloc_result_t want;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				want = apply_command(in_flight);
				results_due.push_back(want);
				cmds_accepted++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (cmds_to_send.size() != 0 && !send_pause()) begin
					in_flight = cmds_to_send.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.kind <= in_flight.kind;
					cmd_ch.page_address <= in_flight.page_address;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		alloc_result_t want;
		alloc_result_t got;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got.status = res_ch.status;
				got.allocated_address = res_ch.allocated_address;
				got.reference_count = res_ch.reference_count;
				got.page_released = res_ch.page_released;
				got.free_pages = res_ch.free_pages;
				if (results_due.size() == 0) begin
					if (mismatch_count < REPORT_MAX)
						$display("result transfer %0d arrived with none expected",
							results_seen);
					mismatch_count++;
				end else begin
					want = results_due.pop_front();
					if (got !== want) begin
						if (mismatch_count < REPORT_MAX)
							$display({"result %0d: expected st=%0d addr=%h cnt=%0d ",
								"rel=%0b free=%0d, got st=%0d addr=%h cnt=%0d ",
								"rel=%0b free=%0d"},
								results_seen, want.status, want.allocated_address,
								want.reference_count, want.page_released, want.free_pages,
								got.status, got.allocated_address, got.reference_count,
								got.page_released, got.free_pages);
						mismatch_count++;
					end
				end
				results_seen++;
			end
			if (hold_left != 0) begin
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= !recv_pause();
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && hold_at >= 0 && results_seen >= hold_at) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** refcounted_page_allocator_top: FAILED **");
			$finish;
		end
	end

	function automatic logic [CFG_ADDR_W-1:0] reg_addr(input reg_idx_t r);
		return CFG_ADDR_W'(r) << REG_SEL_BIT;
	endfunction

	task automatic write_register(input reg_idx_t r, input logic [ADDR_W-1:0] value);
		logic [CFG_DATA_W-1:0] word;
		word = {(CFG_DATA_W - ADDR_W)'($urandom), value};
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= reg_addr(r);
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (r == REG_MEMORY_BASE)
			cfg_base = word[ADDR_W-1:0];
		else
			cfg_usable = word[ADDR_W-1:0];
	endtask

	task automatic check_register(input reg_idx_t r, input logic [ADDR_W-1:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= reg_addr(r);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (prdata !== {{(CFG_DATA_W - ADDR_W){1'b0}}, want}) begin
			if (mismatch_count < REPORT_MAX)
				$display("register %0d: expected %h, got %h", r, want, prdata);
			mismatch_count++;
		end
	endtask

	task automatic set_window(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] usable);
		write_register(REG_MEMORY_BASE, base);
		write_register(REG_USABLE_START, usable);
		check_register(REG_MEMORY_BASE, base);
		check_register(REG_USABLE_START, usable);
	endtask

	task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
		alloc_cmd_t c;
		c.kind = kind;
		c.page_address = addr;
		cmds_to_send.push_back(c);
		cmds_queued++;
	endtask

	task automatic wait_idle();
		while (cmds_accepted != cmds_queued || results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic begin_phase(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] usable,
			input gap_mode_t mode);
		wait_idle();
		gap_mode = mode;
		set_window(base, usable);
		send_cmd(KIND_INIT, ADDR_W'({$urandom, $urandom}));
	endtask

	function automatic logic [ADDR_W-1:0] random_addr();
		longint unsigned lo;
		longint unsigned first;
		int unsigned pick;
		first = init_first_page();
		lo = first;
		if (lo + WINDOW < NUM_PAGES)
			lo = NUM_PAGES - WINDOW;
		if (lo >= NUM_PAGES)
			lo = NUM_PAGES - 1;
		pick = $urandom_range(0, 99);
		if (pick < 72)
			return page_at(lo + $urandom_range(0, int'(NUM_PAGES - 1 - lo)));
		if (pick < 78)
			return (first > 0) ? page_at(first - 1) : ADDR_W'(base_aligned() - PAGE_BYTES);
		if (pick < 84)
			return page_at(NUM_PAGES + $urandom_range(0, 3));
		if (pick < 90)
			return page_at(lo) | ADDR_W'($urandom_range(1, int'(PAGE_MASK)));
		return ADDR_W'({$urandom, $urandom});
	endfunction

	task automatic queue_random(input int n);
		longint unsigned first;
		int unsigned pick;
		bit small_init;
		first = init_first_page();
		small_init = (first >= NUM_PAGES) || (NUM_PAGES - first <= SMALL_INIT);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				send_cmd(pick[0] ? KIND_SPARE_A : KIND_SPARE_B, ADDR_W'({$urandom, $urandom}));
			else if (pick < 5 && small_init)
				send_cmd(KIND_INIT, ADDR_W'({$urandom, $urandom}));
			else if (pick < 35)
				send_cmd(KIND_ALLOC, ADDR_W'({$urandom, $urandom}));
			else if (pick < 60)
				send_cmd(KIND_FREE, random_addr());
			else if (pick < 73)
				send_cmd(KIND_ADD_REF, random_addr());
			else if (pick < 86)
				send_cmd(KIND_DROP_REF, random_addr());
			else
				send_cmd(KIND_READ_COUNT, random_addr());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.kind = '0;
		cmd_ch.page_address = '0;
		res_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		set_window(CFG_RESET, CFG_RESET + ADDR_W'((NUM_PAGES - 16) * PAGE_BYTES));
		send_cmd(KIND_ALLOC, '0);
		send_cmd(KIND_READ_COUNT, page_at(NUM_PAGES - 1));
		send_cmd(KIND_FREE, page_at(NUM_PAGES - 8));
		send_cmd(KIND_INIT, '1);
		send_cmd(KIND_ALLOC, '0);
		send_cmd(KIND_ALLOC, '1);
		send_cmd(KIND_ADD_REF, page_at(NUM_PAGES - 1));
		send_cmd(KIND_DROP_REF, page_at(NUM_PAGES - 1));
		send_cmd(KIND_FREE, page_at(NUM_PAGES - 1));
		send_cmd(KIND_FREE, page_at(NUM_PAGES - 1));
		send_cmd(KIND_DROP_REF, page_at(NUM_PAGES - 2));
		send_cmd(KIND_DROP_REF, page_at(NUM_PAGES - 2));
		send_cmd(KIND_READ_COUNT, page_at(NUM_PAGES - 16));
		send_cmd(KIND_FREE, page_at(NUM_PAGES - 17));
		send_cmd(KIND_ADD_REF, page_at(NUM_PAGES));
		send_cmd(KIND_FREE, page_at(NUM_PAGES - 1) | ADDR_W'(PAGE_BYTES / 2));
		send_cmd(KIND_READ_COUNT, '1);
		send_cmd(KIND_FREE, '0);
		send_cmd(KIND_DROP_REF, page_at(NUM_PAGES - 1) | ADDR_W'(1));
		send_cmd(KIND_SPARE_A, '1);
		send_cmd(KIND_SPARE_B, '0);
		send_cmd(KIND_ALLOC, '0);
		send_cmd(KIND_ALLOC, '0);

		begin_phase('0, ADDR_W'((NUM_PAGES - 40) * PAGE_BYTES + 123), GAPS_SEND);
		queue_random(300);

		// Base at the top of the address space: most page addresses wrap.
		begin_phase('1, '0, GAPS_RECV);
		queue_random(200);

		begin_phase(56'h12_3456_7ABC, '1, GAPS_NONE);
		queue_random(60);

		begin_phase(56'h40_0000_0000_0000,
			56'h40_0000_0000_0000 + ADDR_W'((NUM_PAGES - 32) * PAGE_BYTES), GAPS_BOTH);
		hold_at = results_seen + 30;
		queue_random(300);

		// Drive one page's count into saturation at both ends.
		begin_phase(56'h00_0123_4567_8000, '0, GAPS_SEND);
		send_cmd(KIND_ALLOC, '0);
		repeat (COUNT_MAX + 1) send_cmd(KIND_ADD_REF, page_at(NUM_PAGES - 1));
		repeat (COUNT_MAX + 2) send_cmd(KIND_DROP_REF, page_at(NUM_PAGES - 1));
		send_cmd(KIND_FREE, page_at(NUM_PAGES - 1));
		wait_idle();
		gap_mode = GAPS_RECV;
		queue_random(150);

		wait_idle();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && results_due.size() == 0)
			$display("** refcounted_page_allocator_top: PASSED **");
		else
			$display("** refcounted_page_allocator_top: FAILED **");
		$finish;
	end

endmodule

>>> files.f
design/rpa_pkg.sv
design/rpa_req_if.sv
design/rpa_rsp_if.sv
design/rpa_cfg.sv
design/rpa_ctrl.sv
design/rpa_datapath.sv
design/refcounted_page_allocator_top.sv
dv/tb_refcounted_page_allocator_top.sv
